// File: rtl/core/mtd_pkg.sv
// shared types, header byte codes and field widths for the messagepack token decoder
package mtd_pkg;

	localparam int BYTE_W   = 8;
	localparam int VALUE_W  = 33;
	localparam int ACC_W    = 32;
	localparam int LEN_W    = 32;
	localparam int COUNT_W  = 3;
	localparam int KIND_W   = 3;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 40;

	// header byte codes
	localparam logic [7:0] HB_NIL     = 8'hC0;
	localparam logic [7:0] HB_INT8    = 8'hD0;
	localparam logic [7:0] HB_INT16   = 8'hD1;
	localparam logic [7:0] HB_INT32   = 8'hD2;
	localparam logic [7:0] HB_STR8    = 8'hD9;
	localparam logic [7:0] HB_STR16   = 8'hDA;
	localparam logic [7:0] HB_STR32   = 8'hDB;
	localparam logic [7:0] HB_ARRAY16 = 8'hDC;
	localparam logic [7:0] HB_ARRAY32 = 8'hDD;
	localparam logic [7:0] HB_MAP16   = 8'hDE;
	localparam logic [7:0] HB_MAP32   = 8'hDF;
	localparam logic [7:0] HB_NEGFIX  = 8'hE0;
	localparam logic [7:0] HB_POSMAX  = 8'h7F;
	localparam logic [7:0] HB_MAPMAX  = 8'h8F;
	localparam logic [7:0] HB_ARRMAX  = 8'h9F;
	localparam logic [7:0] HB_STRMAX  = 8'hBF;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_FIELD   = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		PK_INT8   = 3'd0,
		PK_INT16  = 3'd1,
		PK_INT32  = 3'd2,
		PK_ARRAY  = 3'd3,
		PK_MAP    = 3'd4,
		PK_STRING = 3'd5
	} pend_kind_t;

	typedef enum logic [2:0] {
		TK_INT    = 3'd0,
		TK_ARRAY  = 3'd1,
		TK_MAP    = 3'd2,
		TK_STRHDR = 3'd3,
		TK_STRBYT = 3'd4,
		TK_NIL    = 3'd5,
		TK_ERROR  = 3'd6
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t           kind;
		logic [VALUE_W-1:0]  value;
		logic                last;
	} tok_t;

	// what a header byte asks for
	typedef struct packed {
		logic                has_tok;
		tok_t                tok;
		logic                to_field;
		pend_kind_t          field_kind;
		logic [COUNT_W-1:0]  field_bytes;
		logic                to_payload;
		logic [4:0]          payload_len;
	} hdr_info_t;

endpackage

// File: rtl/core/mtd_hdr_decode.sv
// header byte classifier: immediate tokens and the field or payload that follows
module mtd_hdr_decode (
	input  logic [mtd_pkg::BYTE_W-1:0] hdr_byte,
	output mtd_pkg::hdr_info_t         info
);
	import mtd_pkg::*;

	always_comb begin
		info             = '0;
		info.tok.kind    = TK_INT;
		info.field_kind  = PK_INT8;
		if (hdr_byte <= HB_POSMAX) begin
			info.has_tok   = 1'b1;
			info.tok.value = {{(VALUE_W-BYTE_W){1'b0}}, hdr_byte};
		end else if (hdr_byte >= HB_NEGFIX) begin
			info.has_tok   = 1'b1;
			info.tok.value = {{(VALUE_W-BYTE_W){1'b1}}, hdr_byte};
		end else if (hdr_byte <= HB_MAPMAX) begin
			info.has_tok   = 1'b1;
			info.tok.kind  = TK_MAP;
			info.tok.value = {{(VALUE_W-4){1'b0}}, hdr_byte[3:0]};
		end else if (hdr_byte <= HB_ARRMAX) begin
			info.has_tok   = 1'b1;
			info.tok.kind  = TK_ARRAY;
			info.tok.value = {{(VALUE_W-4){1'b0}}, hdr_byte[3:0]};
		end else if (hdr_byte <= HB_STRMAX) begin
			// fixstr: an empty one closes at once
			info.has_tok     = 1'b1;
			info.tok.kind    = TK_STRHDR;
			info.tok.value   = {{(VALUE_W-5){1'b0}}, hdr_byte[4:0]};
			info.tok.last    = (hdr_byte[4:0] == 5'd0);
			info.to_payload  = (hdr_byte[4:0] != 5'd0);
			info.payload_len = hdr_byte[4:0];
		end else begin
			case (hdr_byte)
				HB_NIL: begin
					info.has_tok  = 1'b1;
					info.tok.kind = TK_NIL;
				end
				HB_INT8: begin
					info.to_field    = 1'b1;
					info.field_kind  = PK_INT8;
					info.field_bytes = 3'd1;
				end
				HB_INT16: begin
					info.to_field    = 1'b1;
					info.field_kind  = PK_INT16;
					info.field_bytes = 3'd2;
				end
				HB_INT32: begin
					info.to_field    = 1'b1;
					info.field_kind  = PK_INT32;
					info.field_bytes = 3'd4;
				end
				HB_STR8: begin
					info.to_field    = 1'b1;
					info.field_kind  = PK_STRING;
					info.field_bytes = 3'd1;
				end
				HB_STR16: begin
					info.to_field    = 1'b1;
					info.field_kind  = PK_STRING;
					info.field_bytes = 3'd2;
				end
				HB_STR32: begin
					info.to_field    = 1'b1;
					info.field_kind  = PK_STRING;
					info.field_bytes = 3'd4;
				end
				HB_ARRAY16: begin
					info.to_field    = 1'b1;
					info.field_kind  = PK_ARRAY;
					info.field_bytes = 3'd2;
				end
				HB_ARRAY32: begin
					info.to_field    = 1'b1;
					info.field_kind  = PK_ARRAY;
					info.field_bytes = 3'd4;
				end
				HB_MAP16: begin
					info.to_field    = 1'b1;
					info.field_kind  = PK_MAP;
					info.field_bytes = 3'd2;
				end
				HB_MAP32: begin
					info.to_field    = 1'b1;
					info.field_kind  = PK_MAP;
					info.field_bytes = 3'd4;
				end
				default: begin
					info.has_tok   = 1'b1;
					info.tok.kind  = TK_ERROR;
					info.tok.value = {{(VALUE_W-BYTE_W){1'b0}}, hdr_byte};
				end
			endcase
		end
	end

endmodule

// File: rtl/core/mtd_out_reg.sv
// token output register with stream handshake toward the consumer
module mtd_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  mtd_pkg::tok_t tok_in,
	output logic          free,
	output logic          tvalid,
	input  logic          tready,
	output mtd_pkg::tok_t tok_out
);
	import mtd_pkg::*;

	logic valid_q;
	tok_t tok_q;

	// slot frees up in the same cycle the held token is taken
	assign free    = !valid_q || tready;
	assign tvalid  = valid_q;
	assign tok_out = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q <= tok_in;
		end
	end

endmodule

// File: rtl/core/msgpack_token_decoder_core.sv
// messagepack token decoder top level: input register, decode state and token output
//
//  channel  | dir | tdata                    | tuser              | tlast
//  s_*      | in  | [7:0] stream_byte        | message_start      | -
//  m_*      | out | [32:0] token_value       | [2:0] token_kind   | string_end
//
// one byte per cycle sustained while m_tready does not stall a token; an accepted byte is held
// in the input register, decoded, then loaded into the token register, from which its token leaves
// field-opening header bytes and non-final field bytes produce no token and never wait on m_tready
// reset clears the input and token valids and the decode state; no clearing pass
// a stalled m_tready holds the token register and backs up into the input register
module msgpack_token_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mtd_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] stream_byte
	input  logic                          s_tuser,   // [0] message_start
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mtd_pkg::M_TDATA_W-1:0] m_tdata,   // [32:0] token_value, rest zero
	output logic [mtd_pkg::KIND_W-1:0]    m_tuser,   // [2:0] token_kind
	output logic                          m_tlast    // string_end
);
	import mtd_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                start_s1;

	phase_t              phase_q;
	pend_kind_t          pkind_q;
	logic [COUNT_W-1:0]  fleft_q;
	logic [ACC_W-1:0]    facc_q;
	logic [LEN_W-1:0]    pleft_q;

	phase_t              phase_d;
	pend_kind_t          pkind_d;
	logic [COUNT_W-1:0]  fleft_d;
	logic [ACC_W-1:0]    facc_d;
	logic [LEN_W-1:0]    pleft_d;

	phase_t              eff_phase;
	logic [ACC_W-1:0]    facc_new;
	logic [COUNT_W-1:0]  fleft_new;
	logic [LEN_W-1:0]    pleft_new;
	hdr_info_t           hdr;
	logic                res_valid;
	tok_t                res_tok;
	tok_t                out_tok;
	logic                out_free;
	logic                advance;
	logic                load_s1;

	mtd_hdr_decode u_hdr (
		.hdr_byte (byte_s1),
		.info     (hdr)
	);

	// a start flag makes this byte a header whatever came before
	always_comb begin
		case (phase_q)
			PH_FIELD:   eff_phase = start_s1 ? PH_HEADER : PH_FIELD;
			PH_PAYLOAD: eff_phase = start_s1 ? PH_HEADER : PH_PAYLOAD;
			default:    eff_phase = PH_HEADER;
		endcase
	end

	assign facc_new  = {facc_q[ACC_W-BYTE_W-1:0], byte_s1};
	assign fleft_new = fleft_q - 3'd1;
	assign pleft_new = pleft_q - 32'd1;

	always_comb begin
		phase_d   = phase_q;
		pkind_d   = pkind_q;
		fleft_d   = fleft_q;
		facc_d    = facc_q;
		pleft_d   = pleft_q;
		res_valid = 1'b0;
		res_tok   = '0;
		res_tok.kind = TK_INT;
		case (eff_phase)
			PH_FIELD: begin
				facc_d  = facc_new;
				fleft_d = fleft_new;
				if (fleft_new == '0) begin
					phase_d   = PH_HEADER;
					res_valid = 1'b1;
					case (pkind_q)
						PK_INT8: begin
							res_tok.value = {{(VALUE_W-8){facc_new[7]}}, facc_new[7:0]};
						end
						PK_INT16: begin
							res_tok.value = {{(VALUE_W-16){facc_new[15]}}, facc_new[15:0]};
						end
						PK_INT32: begin
							res_tok.value = {facc_new[ACC_W-1], facc_new};
						end
						PK_ARRAY: begin
							res_tok.kind  = TK_ARRAY;
							res_tok.value = {1'b0, facc_new};
						end
						PK_MAP: begin
							res_tok.kind  = TK_MAP;
							res_tok.value = {1'b0, facc_new};
						end
						default: begin
							res_tok.kind  = TK_STRHDR;
							res_tok.value = {1'b0, facc_new};
							if (facc_new == '0) begin
								res_tok.last = 1'b1;
							end else begin
								pleft_d = facc_new;
								phase_d = PH_PAYLOAD;
							end
						end
					endcase
				end
			end
			PH_PAYLOAD: begin
				pleft_d       = pleft_new;
				res_valid     = 1'b1;
				res_tok.kind  = TK_STRBYT;
				res_tok.value = {{(VALUE_W-BYTE_W){1'b0}}, byte_s1};
				if (pleft_new == '0) begin
					res_tok.last = 1'b1;
					phase_d      = PH_HEADER;
				end
			end
			default: begin
				phase_d   = PH_HEADER;
				res_valid = hdr.has_tok;
				res_tok   = hdr.tok;
				if (hdr.to_field) begin
					phase_d = PH_FIELD;
					pkind_d = hdr.field_kind;
					fleft_d = hdr.field_bytes;
					facc_d  = '0;
				end else if (hdr.to_payload) begin
					phase_d = PH_PAYLOAD;
					pleft_d = {{(LEN_W-5){1'b0}}, hdr.payload_len};
				end
			end
		endcase
	end

	// a byte with no token moves on even while the token register is stalled
	assign advance  = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || advance;
	assign load_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1  <= s_tdata[BYTE_W-1:0];
			start_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pkind_q <= PK_INT8;
			fleft_q <= '0;
			facc_q  <= '0;
			pleft_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			pkind_q <= pkind_d;
			fleft_q <= fleft_d;
			facc_q  <= facc_d;
			pleft_q <= pleft_d;
		end
	end

	mtd_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && res_valid),
		.tok_in  (res_tok),
		.free    (out_free),
		.tvalid  (m_tvalid),
		.tready  (m_tready),
		.tok_out (out_tok)
	);

	assign m_tdata = {{(M_TDATA_W-VALUE_W){1'b0}}, out_tok.value};
	assign m_tuser = out_tok.kind;
	assign m_tlast = out_tok.last;

endmodule

// File: sim/tb_msgpack_token_decoder_core.sv
// testbench for the messagepack token decoder core: random and directed byte streams
`timescale 1ns / 100ps

module tb_msgpack_token_decoder_core;
	import mtd_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_BYTES = 1350;

	// token predictor and store of expected tokens
	class token_scoreboard;
		tok_t               pending[$];
		int                 errors;
		phase_t             phase;
		pend_kind_t         field_kind;
		logic [COUNT_W-1:0] field_left;
		logic [ACC_W-1:0]   field_acc;
		logic [LEN_W-1:0]   payload_left;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase        = PH_HEADER;
			field_kind   = PK_INT8;
			field_left   = '0;
			field_acc    = '0;
			payload_left = '0;
		endfunction

		function void push(tok_kind_t k, logic [VALUE_W-1:0] v, logic l);
			tok_t t;
			t.kind  = k;
			t.value = v;
			t.last  = l;
			pending.push_back(t);
		endfunction

		function void open_field(pend_kind_t k, logic [COUNT_W-1:0] n);
			field_kind = k;
			field_left = n;
			field_acc  = '0;
			phase      = PH_FIELD;
		endfunction

		function void string_header(logic [LEN_W-1:0] len);
			if (len == 0) begin
				phase = PH_HEADER;
				push(TK_STRHDR, '0, 1'b1);
			end else begin
				payload_left = len;
				phase        = PH_PAYLOAD;
				push(TK_STRHDR, {1'b0, len}, 1'b0);
			end
		endfunction

		function void decode_header(logic [7:0] b);
			phase = PH_HEADER;
			if (b <= HB_POSMAX)
				push(TK_INT, {25'd0, b}, 1'b0);
			else if (b >= HB_NEGFIX)
				push(TK_INT, {{25{1'b1}}, b}, 1'b0);
			else if (b <= HB_MAPMAX)
				push(TK_MAP, {29'd0, b[3:0]}, 1'b0);
			else if (b <= HB_ARRMAX)
				push(TK_ARRAY, {29'd0, b[3:0]}, 1'b0);
			else if (b <= HB_STRMAX)
				string_header({27'd0, b[4:0]});
			else begin
				case (b)
					HB_NIL:     push(TK_NIL, '0, 1'b0);
					HB_INT8:    open_field(PK_INT8, 3'd1);
					HB_INT16:   open_field(PK_INT16, 3'd2);
					HB_INT32:   open_field(PK_INT32, 3'd4);
					HB_STR8:    open_field(PK_STRING, 3'd1);
					HB_STR16:   open_field(PK_STRING, 3'd2);
					HB_STR32:   open_field(PK_STRING, 3'd4);
					HB_ARRAY16: open_field(PK_ARRAY, 3'd2);
					HB_ARRAY32: open_field(PK_ARRAY, 3'd4);
					HB_MAP16:   open_field(PK_MAP, 3'd2);
					HB_MAP32:   open_field(PK_MAP, 3'd4);
					default:    push(TK_ERROR, {25'd0, b}, 1'b0);
				endcase
			end
		endfunction

		function void note_request(logic [7:0] b, logic st);
			if (st)
				clear();
			if (phase == PH_FIELD) begin
				field_acc  = {field_acc[23:0], b};
				field_left = field_left - 3'd1;
				if (field_left == 0) begin
					phase = PH_HEADER;
					case (field_kind)
						PK_INT8:  push(TK_INT, {{25{field_acc[7]}}, field_acc[7:0]}, 1'b0);
						PK_INT16: push(TK_INT, {{17{field_acc[15]}}, field_acc[15:0]}, 1'b0);
						PK_INT32: push(TK_INT, {field_acc[31], field_acc}, 1'b0);
						PK_ARRAY: push(TK_ARRAY, {1'b0, field_acc}, 1'b0);
						PK_MAP:   push(TK_MAP, {1'b0, field_acc}, 1'b0);
						default:  string_header(field_acc);
					endcase
				end
			end else if (phase == PH_PAYLOAD) begin
				payload_left = payload_left - 1;
				if (payload_left == 0) begin
					phase = PH_HEADER;
					push(TK_STRBYT, {25'd0, b}, 1'b1);
				end else begin
					push(TK_STRBYT, {25'd0, b}, 1'b0);
				end
			end else begin
				decode_header(b);
			end
		endfunction

		function void check_token(tok_kind_t k, logic [VALUE_W-1:0] v, logic l);
			tok_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected token: expected none, actual kind %0d value %h last %b",
					$time, k, v, l);
				return;
			end
			want = pending.pop_front();
			if (want.kind !== k) begin
				errors++;
				$display("%0t: token_kind: expected %0d, actual %0d", $time, want.kind, k);
			end
			if (want.value !== v) begin
				errors++;
				$display("%0t: token_value: expected %h, actual %h", $time, want.value, v);
			end
			if (want.last !== l) begin
				errors++;
				$display("%0t: string_end: expected %b, actual %b", $time, want.last, l);
			end
		endfunction
	endclass

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]    m_tuser;
	logic                 m_tlast;

	token_scoreboard board = new();
	int  bytes_sent   = 0;
	int  stall_cycles = 0;
	bit  no_gaps      = 1'b0;
	bit  next_start   = 1'b0;
	bit  abandon      = 1'b0;
	bit  may_abandon  = 1'b0;

	msgpack_token_decoder_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_token(tok_kind_t'(m_tuser), m_tdata[VALUE_W-1:0], m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_msgpack_token_decoder_core: errors");
			$finish;
		end
	end

	task automatic send(input logic [7:0] b, input logic st);
		while (!no_gaps && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= st;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_request(b, st);
		bytes_sent++;
		no_gaps = (bytes_sent >= 500 && bytes_sent < 800);
	endtask

	// bytes of a well-formed message; a broken message may stop early
	task automatic put(input logic [7:0] b);
		if (may_abandon && $urandom_range(59) == 0)
			abandon = 1'b1;
		if (!abandon) begin
			send(b, next_start);
			next_start = 1'b0;
		end
	endtask

	task automatic put_random(input int n);
		for (int i = 0; i < n; i++)
			put(8'($urandom_range(255)));
	endtask

	task automatic put_payload(input int len);
		for (int i = 0; i < len; i++)
			put(8'($urandom_range(255)));
	endtask

	task automatic put_token();
		int          pick;
		int          len;
		logic [7:0]  b;
		pick = $urandom_range(13);
		case (pick)
			0: put(8'($urandom_range(8'h7F)));
			1: put(8'($urandom_range(8'hFF, 8'hE0)));
			2: begin put(HB_INT8); put_random(1); end
			3: begin put(HB_INT16); put_random(2); end
			4: begin put(HB_INT32); put_random(4); end
			5: put(HB_NIL);
			6: put(8'($urandom_range(HB_MAPMAX, 8'h80)));
			7: put(8'($urandom_range(HB_ARRMAX, 8'h90)));
			8: begin
				case ($urandom_range(3))
					0: begin put(HB_ARRAY16); put_random(2); end
					1: begin put(HB_ARRAY32); put_random(4); end
					2: begin put(HB_MAP16); put_random(2); end
					default: begin put(HB_MAP32); put_random(4); end
				endcase
			end
			9: begin
				len = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(6);
				put(8'hA0 | len[7:0]);
				put_payload(len);
			end
			10: begin
				len = $urandom_range(12);
				put(HB_STR8);
				put(len[7:0]);
				put_payload(len);
			end
			11: begin
				len = $urandom_range(12);
				put(HB_STR16);
				put(8'h00);
				put(len[7:0]);
				put_payload(len);
			end
			12: begin
				len = $urandom_range(12);
				put(HB_STR32);
				put(8'h00); put(8'h00); put(8'h00);
				put(len[7:0]);
				put_payload(len);
			end
			default: begin
				// unsupported formats in the c1..df range
				do
					b = 8'($urandom_range(8'hDF, 8'hC1));
				while (b inside {HB_INT8, HB_INT16, HB_INT32, HB_STR8, HB_STR16, HB_STR32,
					HB_ARRAY16, HB_ARRAY32, HB_MAP16, HB_MAP32});
				put(b);
			end
		endcase
	endtask

	task automatic directed_stream();
		send(8'h00, 1'b1);
		send(8'h7F, 1'b0);
		send(8'hE0, 1'b0);
		send(8'hFF, 1'b0);
		send(HB_NIL, 1'b0);
		send(8'h8F, 1'b0);
		send(8'h90, 1'b0);
		send(8'hA0, 1'b0);
		send(8'hA1, 1'b0); send(8'h41, 1'b0);
		send(HB_INT8, 1'b0); send(8'h80, 1'b0);
		send(HB_INT16, 1'b0); send(8'h7F, 1'b0); send(8'hFF, 1'b0);
		send(HB_INT32, 1'b0); send(8'h80, 1'b0); send(8'h00, 1'b0);
		send(8'h00, 1'b0); send(8'h00, 1'b0);
		send(HB_STR8, 1'b0); send(8'h00, 1'b0);
		send(HB_STR16, 1'b0); send(8'h00, 1'b0); send(8'h01, 1'b0); send(8'hFF, 1'b0);
		send(HB_STR32, 1'b0); send(8'h00, 1'b0); send(8'h00, 1'b0);
		send(8'h00, 1'b0); send(8'h01, 1'b0); send(8'h00, 1'b0);
		send(HB_ARRAY16, 1'b0); send(8'hFF, 1'b0); send(8'hFF, 1'b0);
		send(HB_ARRAY32, 1'b0); send(8'hFF, 1'b0); send(8'hFF, 1'b0);
		send(8'hFF, 1'b0); send(8'hFF, 1'b0);
		send(HB_MAP16, 1'b0); send(8'h00, 1'b0); send(8'h00, 1'b0);
		send(HB_MAP32, 1'b0); send(8'h12, 1'b0); send(8'h34, 1'b0);
		send(8'h56, 1'b0); send(8'h78, 1'b0);
		send(8'hC1, 1'b0);
		// message start drops a half-gathered int32, then a half-passed string
		send(HB_INT32, 1'b0); send(8'h11, 1'b0);
		send(8'h05, 1'b1);
		send(8'hA3, 1'b0); send(8'h61, 1'b0);
		send(8'hFF, 1'b1);
	endtask

	initial begin
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_stream();
		n = bytes_sent;
		while (bytes_sent < n + RANDOM_BYTES) begin
			if ($urandom_range(19) == 0) begin
				// noise with random message starts
				for (int i = $urandom_range(8, 1); i > 0; i--)
					send(8'($urandom_range(255)), $urandom_range(3) == 0);
			end else begin
				next_start  = 1'b1;
				abandon     = 1'b0;
				may_abandon = ($urandom_range(9) == 0);
				for (int i = $urandom_range(6, 1); i > 0; i--)
					put_token();
			end
		end
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("tb_msgpack_token_decoder_core: clean");
		else
			$display("tb_msgpack_token_decoder_core: errors");
		$finish;
	end

endmodule
